[rtl/rrip_pkg.sv]
`default_nettype none
package rrip_pkg;

   localparam int NUM_SETS    = 2048;
   localparam int NUM_WAYS    = 16;
   localparam int SIG_ENTRIES = 1024;
   localparam int DUEL_SPAN   = 64;

   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int WAY_W   = (NUM_WAYS > 2) ? $clog2(NUM_WAYS) : 1;
   localparam int SIG_W   = $clog2(SIG_ENTRIES);
   localparam int ROW_W   = 2 * NUM_WAYS;
   localparam int CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W   = $clog2(CLR_DEPTH);
   localparam int DUEL_HALF = DUEL_SPAN / 2;

   localparam logic [1:0] RR_MAX   = 2'd3;
   localparam logic [9:0] SEL_MAX  = 10'd1023;
   localparam logic [9:0] SEL_INIT = 10'd512;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [1:0] {
      CSR_STREAM_THR = 2'd0,
      CSR_HOT_THR    = 2'd1,
      CSR_SEL_THR    = 2'd2,
      CSR_STATIC_VAL = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      LEAD_FOLLOWER = 2'd0,
      LEAD_BIMODAL  = 2'd1,
      LEAD_STATIC   = 2'd2
   } leader_type;

   typedef struct packed {
      logic [1:0]  reuse;
      logic [31:0] last_block;
      logic [1:0]  run;
   } sig_entry_type;

   localparam sig_entry_type SIG_RESET = '{reuse: 2'd1, last_block: 32'd0, run: 2'd0};

   function automatic leader_type leader_of(input logic [31:0] set_num);
      logic [31:0] m;
      m = set_num % DUEL_SPAN;
      if (m < 32'(DUEL_HALF)) return LEAD_BIMODAL;
      if (m >= 32'(DUEL_HALF)) return LEAD_STATIC;
      return LEAD_FOLLOWER;
   endfunction

endpackage
`default_nettype wire

[rtl/rrip_replacement_with_reuse_and_stream_top.sv]
`default_nettype none
// Channel  | Direction | Transfer                  | Contents (lowest bit first)
// req_     | in        | req_tvalid & req_tready   | tuser: mode; tdata: set_index, way_index,
//          |           |                           |   was_hit, pc_bits, block_number
// rsp_     | out       | rsp_tvalid & rsp_tready   | tdata: victim_way, written_value, streaming
// csr_     | in        | csr_valid & csr_ready     | csr_index, csr_data
//
// Each request first reads the set row and signature entry from their memories into
// registers, then modifies them, writes back and loads the response register.
// After reset a clearing pass over max(NUM_SETS, SIG_ENTRIES) addresses (2048) initialises
// both memories; no request is taken meanwhile, configuration writes are.
// A pending response that is not taken holds the block in its write-back cycle.
module rrip_replacement_with_reuse_and_stream_top
   import rrip_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // set_index[10:0], way_index[14:11], was_hit[15], pc_bits[37:16],
   // block_number[69:38], zero fill
   input  wire  [REQ_DATA_W-1:0]   req_tdata,
   // mode[0]
   input  wire                     req_tuser,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // victim_way[3:0], written_value[5:4], streaming[6], zero fill
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [1:0]              csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_data
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type             state_ff, state_in;
   logic [CLR_W-1:0]      clr_ff, clr_in;

   logic [1:0]            stream_thr_ff;
   logic [1:0]            hot_thr_ff;
   logic [9:0]            sel_thr_ff;
   logic [1:0]            static_val_ff;
   logic [9:0]            selector_ff, selector_in;

   logic                  mode_ff;
   logic [SET_W-1:0]      set_ff;
   logic [WAY_W-1:0]      way_ff;
   logic                  hit_ff;
   logic [SIG_W-1:0]      sig_ff;
   logic [31:0]           blk_ff;

   logic [ROW_W-1:0]      row_rd_ff;
   sig_entry_type         sig_rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ROW_W-1:0]      reref_mem [NUM_SETS];
   sig_entry_type         sig_mem [SIG_ENTRIES];

   logic                  req_xfer;
   logic                  commit;
   logic [SET_W-1:0]      req_set;
   logic [WAY_W-1:0]      req_way;
   logic [21:0]           req_pc;
   logic [21:0]           pc_mix;
   logic [SIG_W-1:0]      req_sig;

   logic                  row_we;
   logic [SET_W-1:0]      row_waddr;
   logic [ROW_W-1:0]      row_wdata;
   logic                  sig_we;
   logic [SIG_W-1:0]      sig_waddr;
   sig_entry_type         sig_wdata;

   logic                  clr_rows, clr_sigs;

   logic                  has3, has2, has1;
   logic [1:0]            top, add;
   logic [ROW_W-1:0]      aged_row;
   logic [WAY_W-1:0]      victim;
   logic [ROW_W-1:0]      upd_row;
   logic [1:0]            run_new, reuse_new, val;
   logic                  stream;
   leader_type            kind;
   logic                  use_static;
   sig_entry_type         sig_new;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign commit     = (state_ff == ST_EXEC) & (~rsp_valid_ff | rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_set = SET_W'(32'(req_tdata[10:0]) % NUM_SETS);
   assign req_way = WAY_W'(32'(req_tdata[14:11]) % NUM_WAYS);
   assign req_pc  = req_tdata[37:16];
   assign pc_mix  = req_pc ^ (req_pc >> 12);
   assign req_sig = pc_mix[SIG_W-1:0];

   assign clr_rows = ({1'b0, clr_ff} < (CLR_W+1)'(NUM_SETS));
   assign clr_sigs = ({1'b0, clr_ff} < (CLR_W+1)'(SIG_ENTRIES));

   always_comb begin
      has3 = 1'b0;
      has2 = 1'b0;
      has1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         has3 = has3 | (row_rd_ff[2*w +: 2] == 2'd3);
         has2 = has2 | (row_rd_ff[2*w +: 2] == 2'd2);
         has1 = has1 | (row_rd_ff[2*w +: 2] == 2'd1);
      end
      top = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));
      add = RR_MAX - top;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_row[2*w +: 2] = row_rd_ff[2*w +: 2] + add;
      end
      victim = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (aged_row[2*w +: 2] == RR_MAX) victim = WAY_W'(w);
      end

      if (blk_ff == sig_rd_ff.last_block + 32'd1) begin
         run_new = (sig_rd_ff.run < stream_thr_ff) ? sig_rd_ff.run + 2'd1 : sig_rd_ff.run;
      end else begin
         run_new = 2'd0;
      end
      stream = (run_new >= stream_thr_ff);
      kind   = leader_of(32'(set_ff));

      selector_in = selector_ff;
      use_static  = 1'b0;
      if (hit_ff) begin
         val       = 2'd0;
         reuse_new = (sig_rd_ff.reuse < 2'd3) ? sig_rd_ff.reuse + 2'd1 : sig_rd_ff.reuse;
         case (kind)
            LEAD_STATIC:  if (selector_ff < SEL_MAX) selector_in = selector_ff + 10'd1;
            LEAD_BIMODAL: if (selector_ff > 10'd0) selector_in = selector_ff - 10'd1;
            default:      selector_in = selector_ff;
         endcase
      end else begin
         case (kind)
            LEAD_BIMODAL: use_static = 1'b0;
            LEAD_STATIC:  use_static = 1'b1;
            default:      use_static = (selector_ff >= sel_thr_ff);
         endcase
         if (stream) begin
            val = RR_MAX;
         end else if (sig_rd_ff.reuse >= hot_thr_ff) begin
            val = 2'd0;
         end else begin
            val = use_static ? static_val_ff : RR_MAX;
         end
         reuse_new = (sig_rd_ff.reuse > 2'd0) ? sig_rd_ff.reuse - 2'd1 : sig_rd_ff.reuse;
      end
      if (!mode_ff) selector_in = selector_ff;

      upd_row = row_rd_ff;
      upd_row[2*way_ff +: 2] = val;

      sig_new.reuse      = reuse_new;
      sig_new.last_block = blk_ff;
      sig_new.run        = run_new;
   end

   always_comb begin
      row_we    = 1'b0;
      row_waddr = set_ff;
      row_wdata = mode_ff ? upd_row : aged_row;
      sig_we    = 1'b0;
      sig_waddr = sig_ff;
      sig_wdata = sig_new;
      if (state_ff == ST_CLEAR) begin
         row_we    = clr_rows;
         row_waddr = clr_ff[SET_W-1:0];
         row_wdata = '1;
         sig_we    = clr_sigs;
         sig_waddr = clr_ff[SIG_W-1:0];
         sig_wdata = SIG_RESET;
      end else if (commit) begin
         row_we = 1'b1;
         sig_we = mode_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (mode_ff) begin
                  rsp_data_in = RSP_DATA_W'({stream, val, 4'd0});
               end else begin
                  rsp_data_in = RSP_DATA_W'({1'b0, 2'd0, 4'(victim)});
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         selector_ff   <= SEL_INIT;
         stream_thr_ff <= 2'd3;
         hot_thr_ff    <= 2'd2;
         sel_thr_ff    <= 10'd512;
         static_val_ff <= 2'd2;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) selector_ff <= selector_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_STREAM_THR: stream_thr_ff <= csr_data[1:0];
               CSR_HOT_THR:    hot_thr_ff    <= csr_data[1:0];
               CSR_SEL_THR:    sel_thr_ff    <= csr_data[9:0];
               CSR_STATIC_VAL: static_val_ff <= csr_data[1:0];
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
      if (req_xfer) begin
         mode_ff <= req_tuser;
         set_ff  <= req_set;
         way_ff  <= req_way;
         hit_ff  <= req_tdata[15];
         sig_ff  <= req_sig;
         blk_ff  <= req_tdata[69:38];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) reref_mem[row_waddr] <= row_wdata;
      if (req_xfer) row_rd_ff <= reref_mem[req_set];
   end

   always_ff @(posedge clock) begin
      if (sig_we) sig_mem[sig_waddr] <= sig_wdata;
      if (req_xfer) sig_rd_ff <= sig_mem[req_sig];
   end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import rrip_pkg::*;

   localparam int TIMEOUT_CYCLES = 200_000;
   localparam int LONG_HOLD      = 80;

   typedef enum logic {MODE_FIND = 1'b0, MODE_UPDATE = 1'b1} req_mode_type;
   typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} press_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   wire                   csr_ready;
   csr_index_type         csr_index = CSR_STREAM_THR;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bit req_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   bit offering = 1'b0;
   bit hold_request = 1'b0;
   int stall_left = 0;
   int rsp_gap_left = 0;
   int items_sent = 0;

   always #10 clock = ~clock;

   rrip_replacement_with_reuse_and_stream_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   class replacement_predictor;
      typedef struct {
         logic [3:0] victim;
         logic [1:0] value;
         logic       stream;
      } reply_type;

      logic [1:0]  rrpv [NUM_SETS*NUM_WAYS];
      logic [1:0]  reuse [SIG_ENTRIES];
      logic [31:0] last_blk [SIG_ENTRIES];
      logic [1:0]  run [SIG_ENTRIES];
      logic [9:0]  selector;
      logic [1:0]  stream_thr, hot_thr, static_val;
      logic [9:0]  sel_thr;
      reply_type   expected_replies[$];
      int          errors, checked, finds, aged_finds, hits, fills, stream_fills;

      function new();
         foreach (rrpv[i]) rrpv[i] = RR_MAX;
         foreach (reuse[i]) begin
            reuse[i] = 2'd1;
            last_blk[i] = '0;
            run[i] = '0;
         end
         selector = SEL_INIT;
         stream_thr = 2'd3;
         hot_thr = 2'd2;
         sel_thr = 10'd512;
         static_val = 2'd2;
      endfunction

      function void write_register(csr_index_type idx, logic [9:0] v);
         case (idx)
            CSR_STREAM_THR: stream_thr = v[1:0];
            CSR_HOT_THR:    hot_thr = v[1:0];
            CSR_SEL_THR:    sel_thr = v;
            CSR_STATIC_VAL: static_val = v[1:0];
         endcase
      endfunction

      function int outstanding();
         return expected_replies.size();
      endfunction

      function reply_type note_access(req_mode_type mode, logic [REQ_DATA_W-1:0] word);
         logic [10:0] set_num;
         logic [3:0]  way;
         logic        hit;
         logic [21:0] pc;
         logic [31:0] blk;
         logic [1:0]  top, val;
         logic [9:0]  sig;
         logic        stream, use_static;
         leader_type  kind;
         int          base;
         reply_type   r;
         set_num = word[10:0];
         way = word[14:11];
         hit = word[15];
         pc = word[37:16];
         blk = word[69:38];
         base = int'(set_num) * NUM_WAYS;
         r.victim = '0;
         r.value = '0;
         r.stream = 1'b0;
         if (mode == MODE_FIND) begin
            finds++;
            top = '0;
            for (int w = 0; w < NUM_WAYS; w++)
               if (rrpv[base+w] > top) top = rrpv[base+w];
            if (top != RR_MAX) begin
               aged_finds++;
               for (int w = 0; w < NUM_WAYS; w++) rrpv[base+w] = rrpv[base+w] + (RR_MAX - top);
            end
            for (int w = NUM_WAYS - 1; w >= 0; w--)
               if (rrpv[base+w] == RR_MAX) r.victim = 4'(w);
         end else begin
            sig = pc[9:0] ^ pc[21:12];
            kind = (int'(set_num) % DUEL_SPAN < DUEL_HALF) ? LEAD_BIMODAL : LEAD_STATIC;
            if (blk == last_blk[sig] + 32'd1) begin
               if (run[sig] < stream_thr) run[sig]++;
            end else begin
               run[sig] = '0;
            end
            last_blk[sig] = blk;
            stream = run[sig] >= stream_thr;
            if (hit) begin
               hits++;
               val = '0;
               if (reuse[sig] != 2'd3) reuse[sig]++;
               if (kind == LEAD_STATIC && selector != SEL_MAX) selector++;
               else if (kind == LEAD_BIMODAL && selector != '0) selector--;
            end else begin
               fills++;
               if (stream) begin
                  stream_fills++;
                  val = RR_MAX;
               end else if (reuse[sig] >= hot_thr) begin
                  val = '0;
               end else begin
                  use_static = (kind == LEAD_STATIC) ||
                               (kind == LEAD_FOLLOWER && selector >= sel_thr);
                  val = use_static ? static_val : RR_MAX;
               end
               if (reuse[sig] != '0) reuse[sig]--;
            end
            rrpv[base+int'(way)] = val;
            r.value = val;
            r.stream = stream;
         end
         expected_replies.push_back(r);
         return r;
      endfunction

      function void check_reply(logic [RSP_DATA_W-1:0] d);
         reply_type e;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: response with none outstanding, expected nothing, actual %h", $time, d);
            return;
         end
         e = expected_replies.pop_front();
         checked++;
         if (d[3:0] !== e.victim) begin
            errors++;
            $display("%0t: victim_way expected %0d actual %0d", $time, e.victim, d[3:0]);
         end
         if (d[5:4] !== e.value) begin
            errors++;
            $display("%0t: written_value expected %0d actual %0d", $time, e.value, d[5:4]);
         end
         if (d[6] !== e.stream) begin
            errors++;
            $display("%0t: streaming expected %0d actual %0d", $time, e.stream, d[6]);
         end
      endfunction
   endclass

   replacement_predictor tracker = new();

   // check each transfer, then choose next-cycle ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_reply(rsp_tdata);
      if (hold_request) begin
         stall_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
         rsp_gap_left = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * 20);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic access(input req_mode_type mode, input logic [10:0] set_num,
                         input logic [3:0] way, input logic hit, input logic [21:0] pc,
                         input logic [31:0] blk, output logic [3:0] victim);
      logic [REQ_DATA_W-1:0] word;
      replacement_predictor::reply_type r;
      word = {2'b00, blk, pc, hit, way, set_num};
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= word;
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      r = tracker.note_access(mode, word);
      victim = r.victim;
      items_sent++;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic stop_requests();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [1:0] stream_thr, input logic [1:0] hot_thr,
                                 input logic [9:0] sel_thr, input logic [1:0] static_val);
      csr_index_type idx [4];
      logic [9:0]    vals [4];
      idx = '{CSR_STREAM_THR, CSR_HOT_THR, CSR_SEL_THR, CSR_STATIC_VAL};
      vals = '{10'(stream_thr), 10'(hot_thr), sel_thr, 10'(static_val)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         tracker.write_register(idx[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic traffic(input int count, input bit quiet, input press_type pressure);
      logic [10:0] sets [6];
      logic [21:0] pcs [6];
      logic [31:0] cursor [6];
      logic [3:0]  v, spare;
      logic [10:0] s;
      logic [31:0] blk;
      int          n, r, j, next_flip;
      bit          pressed;
      foreach (sets[i]) begin
         sets[i] = 11'($urandom);
         pcs[i] = 22'($urandom);
         cursor[i] = $urandom;
      end
      cursor[0] = 32'hFFFF_FFF0;
      n = 0;
      next_flip = 0;
      pressed = 1'b0;
      while (n < count) begin
         if (n >= next_flip) begin
            req_gaps = !quiet && $urandom_range(0, 2) != 0;
            rsp_gaps = !quiet && $urandom_range(0, 2) != 0;
            next_flip = n + $urandom_range(20, 60);
         end
         if (!pressed && n >= count / 2) begin
            pressed = 1'b1;
            if (pressure == PRESS_HOLD) begin
               hold_request = 1'b1;
            end else if (pressure == PRESS_PAUSE) begin
               stop_requests();
               wait_drained();
            end
         end
         r = $urandom_range(0, 99);
         j = $urandom_range(0, 5);
         s = ($urandom_range(0, 9) == 0) ? 11'($urandom) : sets[$urandom_range(0, 5)];
         blk = ($urandom_range(0, 9) < 7) ? cursor[j] + 32'd1 : $urandom;
         if (r < 10) begin
            access(req_mode_type'($urandom_range(0, 1)), 11'($urandom), 4'($urandom),
                   1'($urandom), 22'($urandom), $urandom, spare);
            n += 1;
         end else if (r < 55) begin
            cursor[j] = blk;
            access(MODE_FIND, s, 4'($urandom), 1'($urandom), pcs[j], $urandom, v);
            access(MODE_UPDATE, s, v, 1'b0, pcs[j], blk, spare);
            n += 2;
         end else begin
            cursor[j] = blk;
            access(MODE_UPDATE, s, 4'($urandom), 1'b1, pcs[j], blk, spare);
            n += 1;
         end
      end
   endtask

   task automatic next_phase(input logic [1:0] stream_thr, input logic [1:0] hot_thr,
                             input logic [9:0] sel_thr, input logic [1:0] static_val);
      stop_requests();
      wait_drained();
      write_settings(stream_thr, hot_thr, sel_thr, static_val);
   endtask

   initial begin
      logic [3:0] v;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_settings(2'd3, 2'd2, 10'd512, 2'd2);

      // fresh set, stride build-up to a stream fill, then a full set of hits
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      access(MODE_FIND, 11'd0, 4'd0, 1'b0, 22'd0, 32'd0, v);
      access(MODE_UPDATE, 11'd0, 4'd0, 1'b0, 22'd0, 32'd1, v);
      access(MODE_UPDATE, 11'd0, 4'd0, 1'b1, 22'd0, 32'd2, v);
      access(MODE_UPDATE, 11'd0, 4'd15, 1'b0, 22'd0, 32'd3, v);
      for (int w = 0; w < NUM_WAYS; w++)
         access(MODE_UPDATE, 11'd2047, 4'(w), 1'b1, 22'h3FFFFF, 32'hFFFF_FFFF + 32'(w), v);
      access(MODE_FIND, 11'd2047, 4'd0, 1'b0, 22'd0, 32'd0, v);
      access(MODE_FIND, 11'd2047, 4'd15, 1'b1, 22'h3FFFFF, 32'hFFFF_FFFF, v);
      access(MODE_UPDATE, 11'd2047, 4'd15, 1'b0, 22'h3FFFFF, 32'd15, v);
      access(MODE_UPDATE, 11'd1, 4'd7, 1'b0, 22'h155555, 32'hAAAA_AAAA, v);

      traffic(236, 1'b0, PRESS_NONE);
      next_phase(2'd1, 2'd0, 10'd0, 2'd0);
      traffic(236, 1'b0, PRESS_HOLD);
      next_phase(2'd0, 2'd3, 10'd1023, 2'd3);
      traffic(236, 1'b0, PRESS_PAUSE);
      next_phase(2'd2, 2'd1, 10'd300, 2'd1);
      traffic(236, 1'b0, PRESS_HOLD);
      next_phase(2'd3, 2'd3, 10'd700, 2'd2);
      traffic(236, 1'b1, PRESS_NONE);

      stop_requests();
      wait_drained();
      repeat (8) @(posedge clock);
      $display("Covered %0d requests over five register settings: %0d finds (%0d aged),",
               items_sent, tracker.finds, tracker.aged_finds);
      $display("%0d hits, %0d miss fills (%0d streaming); %0d responses compared",
               tracker.hits, tracker.fills, tracker.stream_fills, tracker.checked);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
